@@ rtl/kts_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, sizes and codes for the topological sorter.
package kts_pkg;

    localparam int MAX_NODES = 32;
    localparam int MAX_EDGES = 128;

    localparam int NODE_W = 5;                          // node index field width
    localparam int CNT_W  = 6;                          // node_count register width
    localparam int EDGE_W = 2 * NODE_W;                 // {dependent, dependency}
    localparam int EA_W   = $clog2(MAX_EDGES);          // edge memory address
    localparam int EC_W   = $clog2(MAX_EDGES + 1);      // edge fill count
    localparam int DEG_W  = $clog2(MAX_EDGES + 1);      // in-degree counter
    localparam int STS_W  = 3;

    // request codes
    localparam logic REQ_EDGE  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // result status codes
    localparam logic [STS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STS_W-1:0] STS_EMPTY    = 3'd1;
    localparam logic [STS_W-1:0] STS_CYCLE    = 3'd2;
    localparam logic [STS_W-1:0] STS_RANGE    = 3'd3;
    localparam logic [STS_W-1:0] STS_OVERFLOW = 3'd4;

    // configuration register index (word address bit)
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef struct packed {
        logic              req_type;
        logic [NODE_W-1:0] dependent_index;
        logic [NODE_W-1:0] dependency_index;
    } t_req;

    typedef struct packed {
        logic [NODE_W-1:0] node_index;
        logic [STS_W-1:0]  status;
        logic              last;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_PICK,
        S_DEC,
        S_EMIT,
        S_STATUS
    } t_state;

endpackage

@@ rtl/kts_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module kts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/kts_core.sv @@
`timescale 1ns / 1ps
// Sort engine: edge memory, in-degree memory, sequencer and result register.
module kts_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  kts_pkg::t_req             i_req,
    input  logic [kts_pkg::CNT_W-1:0] i_node_count,
    output logic                      o_busy,
    output logic                      o_valid,
    output kts_pkg::t_res             o_res
);

    kts_pkg::t_state r_state, n_state;

    logic [kts_pkg::EC_W-1:0]   r_edge_cnt, n_edge_cnt;
    logic                       r_ovf, n_ovf;
    logic [kts_pkg::EC_W-1:0]   r_e, n_e;
    logic                       r_s1, n_s1;
    logic                       r_s2, n_s2;
    logic [kts_pkg::NODE_W-1:0] r_s2_dep, n_s2_dep;
    logic                       r_fw_en, n_fw_en;
    logic [kts_pkg::NODE_W-1:0] r_fw_addr, n_fw_addr;
    logic [kts_pkg::DEG_W-1:0]  r_fw_data, n_fw_data;
    logic [kts_pkg::MAX_NODES-1:0] r_iv, n_iv;
    logic [kts_pkg::MAX_NODES-1:0] r_nz, n_nz;
    logic [kts_pkg::MAX_NODES-1:0] r_done, n_done;
    logic [kts_pkg::CNT_W-1:0]  r_placed, n_placed;
    logic [kts_pkg::NODE_W-1:0] r_pick, n_pick;
    logic [kts_pkg::CNT_W-1:0]  r_emit_i, n_emit_i;
    logic [kts_pkg::STS_W-1:0]  r_sts, n_sts;
    logic                       r_out_valid, n_out_valid;
    kts_pkg::t_res              r_out, n_out;
    logic [kts_pkg::NODE_W-1:0] r_order [kts_pkg::MAX_NODES];

    // memory ports
    logic                        edge_we;
    logic [kts_pkg::EA_W-1:0]    edge_wa;
    logic [kts_pkg::EDGE_W-1:0]  edge_wd;
    logic [kts_pkg::EA_W-1:0]    edge_ra;
    logic [kts_pkg::EDGE_W-1:0]  edge_rd;
    logic                        deg_we;
    logic [kts_pkg::NODE_W-1:0]  deg_wa;
    logic [kts_pkg::DEG_W-1:0]   deg_wd;
    logic [kts_pkg::NODE_W-1:0]  deg_ra;
    logic [kts_pkg::DEG_W-1:0]   deg_rd;

    logic [kts_pkg::NODE_W-1:0]    edge_dep;
    logic [kts_pkg::NODE_W-1:0]    edge_pre;
    logic                          edge_bad;
    logic                          fw_hit;
    logic [kts_pkg::DEG_W-1:0]     deg_val;
    logic [kts_pkg::MAX_NODES-1:0] node_mask;
    logic [kts_pkg::MAX_NODES-1:0] ready;
    logic [kts_pkg::NODE_W-1:0]    pick;
    logic                          order_we;
    logic                          emit_last;

    kts_ram #(
        .WIDTH (kts_pkg::EDGE_W),
        .DEPTH (kts_pkg::MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_wa),
        .i_wdata (edge_wd),
        .i_raddr (edge_ra),
        .o_rdata (edge_rd)
    );

    kts_ram #(
        .WIDTH (kts_pkg::DEG_W),
        .DEPTH (kts_pkg::MAX_NODES)
    ) u_deg_ram (
        .i_clk   (i_clk),
        .i_we    (deg_we),
        .i_waddr (deg_wa),
        .i_wdata (deg_wd),
        .i_raddr (deg_ra),
        .o_rdata (deg_rd)
    );

    assign edge_dep = edge_rd[kts_pkg::EDGE_W-1:kts_pkg::NODE_W];
    assign edge_pre = edge_rd[kts_pkg::NODE_W-1:0];
    assign edge_bad = ({1'b0, edge_dep} >= i_node_count) || ({1'b0, edge_pre} >= i_node_count);

    // in-degree read value: forward last cycle's write, unwritten entries read as zero
    assign fw_hit  = r_fw_en && (r_fw_addr == r_s2_dep);
    assign deg_val = fw_hit ? r_fw_data : (r_iv[r_s2_dep] ? deg_rd : '0);

    always_comb begin
        for (int i = 0; i < kts_pkg::MAX_NODES; i++) begin
            node_mask[i] = (kts_pkg::CNT_W'(i) < i_node_count);
        end
    end

    assign ready = ~r_nz & ~r_done & node_mask;

    // lowest-index ready node
    always_comb begin
        pick = '0;
        for (int i = kts_pkg::MAX_NODES - 1; i >= 0; i--) begin
            if (ready[i]) begin
                pick = kts_pkg::NODE_W'(i);
            end
        end
    end

    assign emit_last = (kts_pkg::CNT_W'(r_emit_i + kts_pkg::CNT_W'(1)) == i_node_count);

    always_comb begin
        n_state     = r_state;
        n_edge_cnt  = r_edge_cnt;
        n_ovf       = r_ovf;
        n_e         = r_e;
        n_s1        = 1'b0;
        n_s2        = 1'b0;
        n_s2_dep    = edge_dep;
        n_iv        = r_iv;
        n_nz        = r_nz;
        n_done      = r_done;
        n_placed    = r_placed;
        n_pick      = r_pick;
        n_emit_i    = r_emit_i;
        n_sts       = r_sts;
        n_out_valid = 1'b0;
        n_out       = r_out;
        order_we    = 1'b0;
        edge_we     = 1'b0;
        edge_wa     = r_edge_cnt[kts_pkg::EA_W-1:0];
        edge_wd     = {i_req.dependent_index, i_req.dependency_index};
        edge_ra     = r_e[kts_pkg::EA_W-1:0];
        deg_ra      = edge_dep;
        deg_we      = 1'b0;
        deg_wa      = r_s2_dep;
        deg_wd      = deg_val + kts_pkg::DEG_W'(1);

        case (r_state)
            kts_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_req.req_type == kts_pkg::REQ_EDGE) begin
                        if (r_edge_cnt == kts_pkg::EC_W'(kts_pkg::MAX_EDGES)) begin
                            n_ovf = 1'b1;
                        end else begin
                            edge_we    = 1'b1;
                            n_edge_cnt = r_edge_cnt + kts_pkg::EC_W'(1);
                        end
                    end else if (r_ovf) begin
                        n_sts   = kts_pkg::STS_OVERFLOW;
                        n_state = kts_pkg::S_STATUS;
                    end else if (i_node_count > kts_pkg::CNT_W'(kts_pkg::MAX_NODES)) begin
                        n_sts   = kts_pkg::STS_RANGE;
                        n_state = kts_pkg::S_STATUS;
                    end else if (i_node_count == '0) begin
                        n_sts   = kts_pkg::STS_EMPTY;
                        n_state = kts_pkg::S_STATUS;
                    end else begin
                        n_iv     = '0;
                        n_nz     = '0;
                        n_done   = '0;
                        n_placed = '0;
                        n_e      = '0;
                        n_state  = kts_pkg::S_COUNT;
                    end
                end
            end

            kts_pkg::S_COUNT, kts_pkg::S_DEC: begin
                // issue: read the next edge
                if (r_e != r_edge_cnt) begin
                    n_e  = r_e + kts_pkg::EC_W'(1);
                    n_s1 = 1'b1;
                end
                // edge word back: read in-degree of its dependent
                if (r_s1) begin
                    if (r_state == kts_pkg::S_COUNT) begin
                        n_s2 = 1'b1;
                    end else begin
                        n_s2 = (edge_pre == r_pick);
                    end
                end
                // in-degree back: update and write
                if (r_s2) begin
                    if (r_state == kts_pkg::S_COUNT) begin
                        deg_we         = 1'b1;
                        n_iv[r_s2_dep] = 1'b1;
                        n_nz[r_s2_dep] = 1'b1;
                    end else if (deg_val != '0) begin
                        deg_we = 1'b1;
                        deg_wd = deg_val - kts_pkg::DEG_W'(1);
                        if (deg_val == kts_pkg::DEG_W'(1)) begin
                            n_nz[r_s2_dep] = 1'b0;
                        end
                    end
                end
                if ((r_state == kts_pkg::S_COUNT) && r_s1 && edge_bad) begin
                    n_sts   = kts_pkg::STS_RANGE;
                    n_s1    = 1'b0;
                    n_s2    = 1'b0;
                    n_state = kts_pkg::S_STATUS;
                end else if ((r_e == r_edge_cnt) && !r_s1 && !r_s2) begin
                    n_state = kts_pkg::S_PICK;
                end
            end

            kts_pkg::S_PICK: begin
                if (r_placed == i_node_count) begin
                    n_emit_i = '0;
                    n_state  = kts_pkg::S_EMIT;
                end else if (ready == '0) begin
                    n_sts   = kts_pkg::STS_CYCLE;
                    n_state = kts_pkg::S_STATUS;
                end else begin
                    n_done[pick] = 1'b1;
                    order_we     = 1'b1;
                    n_placed     = r_placed + kts_pkg::CNT_W'(1);
                    n_pick       = pick;
                    n_e          = '0;
                    n_state      = kts_pkg::S_DEC;
                end
            end

            kts_pkg::S_EMIT: begin
                n_out.node_index = r_order[r_emit_i[kts_pkg::NODE_W-1:0]];
                n_out.status     = kts_pkg::STS_OK;
                n_out.last       = emit_last;
                n_out_valid      = 1'b1;
                n_emit_i         = r_emit_i + kts_pkg::CNT_W'(1);
                if (emit_last) begin
                    n_edge_cnt = '0;
                    n_ovf      = 1'b0;
                    n_state    = kts_pkg::S_IDLE;
                end
            end

            kts_pkg::S_STATUS: begin
                n_out.node_index = '0;
                n_out.status     = r_sts;
                n_out.last       = 1'b1;
                n_out_valid      = 1'b1;
                n_edge_cnt       = '0;
                n_ovf            = 1'b0;
                n_state          = kts_pkg::S_IDLE;
            end

            default: begin
                n_state = kts_pkg::S_IDLE;
            end
        endcase

        n_fw_en   = deg_we;
        n_fw_addr = deg_wa;
        n_fw_data = deg_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kts_pkg::S_IDLE;
            r_edge_cnt  <= '0;
            r_ovf       <= 1'b0;
            r_e         <= '0;
            r_s1        <= 1'b0;
            r_s2        <= 1'b0;
            r_fw_en     <= 1'b0;
            r_iv        <= '0;
            r_nz        <= '0;
            r_done      <= '0;
            r_placed    <= '0;
            r_emit_i    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_edge_cnt  <= n_edge_cnt;
            r_ovf       <= n_ovf;
            r_e         <= n_e;
            r_s1        <= n_s1;
            r_s2        <= n_s2;
            r_fw_en     <= n_fw_en;
            r_iv        <= n_iv;
            r_nz        <= n_nz;
            r_done      <= n_done;
            r_placed    <= n_placed;
            r_emit_i    <= n_emit_i;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_dep  <= n_s2_dep;
        r_fw_addr <= n_fw_addr;
        r_fw_data <= n_fw_data;
        r_pick    <= n_pick;
        r_sts     <= n_sts;
        r_out     <= n_out;
        if (order_we) begin
            r_order[r_placed[kts_pkg::NODE_W-1:0]] <= pick;
        end
    end

    assign o_busy  = (r_state != kts_pkg::S_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

@@ rtl/kahn_topological_sort.sv @@
`timescale 1ns / 1ps
// Top level: APB node_count register and the Kahn topological sort engine.
//
// Usage
//   Input words go in on i_req with start; a word is taken on a clock edge
//   where start is high and busy is low. req_type REQ_EDGE stores one
//   (dependent, dependency) edge and gives no result; busy
//   stays low, so edges can stream in back to back, one per cycle.
//   req_type REQ_START sorts nodes 0..node_count-1 over the stored edges.
//   Results come out on o_res for exactly one cycle each, marked by o_valid:
//   either node_count ordered nodes (status OK, last on the final one) or a
//   single status word with last set. The receiver cannot hold results off.
// Timing
//   Status words for overflow, bad node_count or empty graph come through
//   the S_STATUS state and the result register. A full sort makes one pass
//   over the edge memory to count in-degrees, then one pass per node picked,
//   through its single read port, then node_count result words. A bad edge
//   index or a cycle ends the run early with one status word. The user must
//   write node_count through APB (byte address 0) only while idle (not enforced).
// Reset
//   Clears the edge fill count, the overflow flag and node_count; the memory
//   contents are not cleared and need no clearing pass.
module kahn_topological_sort (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command channel
    input  logic                      start,
    output logic                      busy,
    input  kts_pkg::t_req             i_req,
    // result channel
    output logic                      o_valid,
    output kts_pkg::t_res             o_res,
    // APB configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [kts_pkg::CNT_W-1:0] r_node_count;
    logic                      reg_hit;

    // word address bit selects the register; the byte address bits must be zero
    assign reg_hit = (paddr[2] == kts_pkg::REG_NODE_COUNT) && (paddr[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_node_count <= pwdata[kts_pkg::CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_hit ? {{(32 - kts_pkg::CNT_W){1'b0}}, r_node_count} : '0;

    // sort engine
    kts_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req        (i_req),
        .i_node_count (r_node_count),
        .o_busy       (busy),
        .o_valid      (o_valid),
        .o_res        (o_res)
    );

`ifndef SYNTH
    // the final word of a run is never followed directly by another word
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.last |=> !o_valid)
        else $error("result word right after a last word");

    // a status word is always a lone last word with node index zero
    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_res.status != kts_pkg::STS_OK) |-> o_res.last && (o_res.node_index == '0))
        else $error("status word without last or with a node index");

    // an edge load finishes in its own cycle
    a_edge_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.req_type == kts_pkg::REQ_EDGE) |=> !busy)
        else $error("edge load left the block busy");

    // a sort request always makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.req_type == kts_pkg::REQ_START) |=> busy)
        else $error("sort request not taken up");
`endif

endmodule
